// File: hdl/lcs_pkg.sv
// shared types and constants for the least-connections server selector
// no dependencies
package lcs_pkg;

   localparam int NUM_SERVERS = 8;
   localparam int COUNT_BITS  = 16;
   localparam int LIFE_BITS   = 32;
   localparam int IDX_BITS    = 3;
   localparam int MASK_BITS   = 8;
   localparam int STATUS_BITS = 2;
   localparam int CNT_BITS    = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

   localparam logic KIND_SELECT  = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_SERVER = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_AT_ZERO   = 2'd2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // best candidate so far plus the release hit flags, walked along the cell chain
   typedef struct packed {
      logic                  found;
      logic [COUNT_BITS-1:0] cur;
      logic [LIFE_BITS-1:0]  life;
      logic [IDX_BITS-1:0]   idx;
      logic                  hit;
      logic                  zero;
   } token_type;

   typedef struct packed {
      logic                 kind;
      logic [IDX_BITS-1:0]  rel;
      logic [MASK_BITS-1:0] mask;
   } cmd_type;

   typedef struct packed {
      logic shift;
      logic commit;
   } ctl_type;

   typedef struct packed {
      logic inc;
      logic dec;
   } upd_type;

endpackage

// File: hdl/lcs_cell.sv
// one server cell: current and lifetime counters plus one stage of the token chain
// depends on lcs_pkg
module lcs_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift,
   input  logic                         sel_en,
   input  logic                         rel_en,
   input  logic [lcs_pkg::IDX_BITS-1:0] my_index,
   input  lcs_pkg::upd_type             upd,
   input  lcs_pkg::token_type           tok_i,
   output lcs_pkg::token_type           tok_o
);
   import lcs_pkg::*;

   logic [COUNT_BITS-1:0] cur_ff, cur_in;
   logic [LIFE_BITS-1:0]  life_ff, life_in;
   token_type             tok_ff, tok_in;
   logic                  take;

   always_comb begin
      take = sel_en && (!tok_i.found || (cur_ff < tok_i.cur) ||
                        ((cur_ff == tok_i.cur) && (life_ff < tok_i.life)));
      tok_in = tok_i;
      if (take) begin
         tok_in.found = 1'b1;
         tok_in.cur   = cur_ff;
         tok_in.life  = life_ff;
         tok_in.idx   = my_index;
      end
      if (rel_en) begin
         tok_in.hit  = 1'b1;
         tok_in.zero = (cur_ff == '0);
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      life_in = life_ff;
      if (upd.inc) begin
         if (cur_ff != COUNT_MAX) begin
            cur_in = cur_ff + 1'b1;
         end
         life_in = life_ff + 1'b1;
      end else if (upd.dec) begin
         cur_in = cur_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         life_ff <= '0;
      end else begin
         cur_ff  <= cur_in;
         life_ff <= life_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

// File: hdl/lcs_ctrl.sv
// sequencer: takes a request, runs the token through the chain, commits and responds
// depends on lcs_pkg
module lcs_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic [lcs_pkg::IDX_BITS-1:0]    req_release_index,
   input  logic [lcs_pkg::MASK_BITS-1:0]   req_running_mask,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lcs_pkg::IDX_BITS-1:0]    rsp_chosen_index,
   output logic [lcs_pkg::STATUS_BITS-1:0] rsp_status,
   input  lcs_pkg::token_type              tok_last,
   output lcs_pkg::cmd_type                cmd,
   output lcs_pkg::ctl_type                ctl
);
   import lcs_pkg::*;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   cmd_type                 cmd_ff, cmd_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic                    load;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      load         = 1'b0;
      ctl.shift    = 1'b0;
      ctl.commit   = 1'b0;
      req_stall    = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in.kind = req_kind;
               cmd_in.rel  = req_release_index;
               cmd_in.mask = req_running_mask;
               cnt_in      = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.shift = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(NUM_SERVERS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.commit   = 1'b1;
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd_ff.kind == KIND_SELECT) begin
         if (tok_last.found) begin
            rsp_idx_in    = tok_last.idx;
            rsp_status_in = STATUS_OK;
         end else begin
            rsp_idx_in    = '0;
            rsp_status_in = STATUS_NO_SERVER;
         end
      end else begin
         rsp_idx_in    = cmd_ff.rel;
         rsp_status_in = (tok_last.hit && !tok_last.zero) ? STATUS_OK : STATUS_AT_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      cmd_ff <= cmd_in;
      if (load) begin
         rsp_idx_ff    <= rsp_idx_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign cmd              = cmd_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_index = rsp_idx_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// File: hdl/least_connections_server_select.sv
// a request is taken in idle, the token walks the cell chain in scan, and done commits
// and loads the response; one item at a time, the token moving one server cell per cycle;
// a waiting response does not block the next request, it only delays that request's commit
// reset: synchronous, clears every cell's counters at once and empties the response register
// top level: sequencer plus a chain of server cells; depends on lcs_pkg, lcs_cell, lcs_ctrl
module least_connections_server_select (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic [lcs_pkg::IDX_BITS-1:0]    req_release_index,
   input  logic [lcs_pkg::MASK_BITS-1:0]   req_running_mask,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lcs_pkg::IDX_BITS-1:0]    rsp_chosen_index,
   output logic [lcs_pkg::STATUS_BITS-1:0] rsp_status
);
   import lcs_pkg::*;

   token_type tok_chain [0:NUM_SERVERS];
   cmd_type   cmd;
   ctl_type   ctl;

   assign tok_chain[0] = '0;

   lcs_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_release_index (req_release_index),
      .req_running_mask  (req_running_mask),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_chosen_index  (rsp_chosen_index),
      .rsp_status        (rsp_status),
      .tok_last          (tok_chain[NUM_SERVERS]),
      .cmd               (cmd),
      .ctl               (ctl)
   );

   for (genvar i = 0; i < NUM_SERVERS; i++) begin : g_cell
      logic                sel_en;
      logic                rel_en;
      logic [IDX_BITS-1:0] my_index;
      upd_type             upd;

      if (i < MASK_BITS) begin : g_addr
         assign my_index = IDX_BITS'(i);
         assign sel_en   = (cmd.kind == KIND_SELECT) && cmd.mask[i];
         assign rel_en   = (cmd.kind == KIND_RELEASE) && (cmd.rel == IDX_BITS'(i));
      end else begin : g_noaddr
         assign my_index = '0;
         assign sel_en   = 1'b0;
         assign rel_en   = 1'b0;
      end

      assign upd.inc = ctl.commit && sel_en && tok_chain[NUM_SERVERS].found &&
                       (tok_chain[NUM_SERVERS].idx == my_index);
      assign upd.dec = ctl.commit && rel_en && !tok_chain[NUM_SERVERS].zero;

      lcs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (ctl.shift),
         .sel_en   (sel_en),
         .rel_en   (rel_en),
         .my_index (my_index),
         .upd      (upd),
         .tok_i    (tok_chain[i]),
         .tok_o    (tok_chain[i+1])
      );
   end

endmodule

// File: hdl/lcs_checker.sv
// port-level checks for the least-connections server selector, bound to the top level
// depends on lcs_pkg and least_connections_server_select
module lcs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_kind,
   input logic [lcs_pkg::IDX_BITS-1:0]    req_release_index,
   input logic [lcs_pkg::MASK_BITS-1:0]   req_running_mask,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [lcs_pkg::IDX_BITS-1:0]    rsp_chosen_index,
   input logic [lcs_pkg::STATUS_BITS-1:0] rsp_status
);
   import lcs_pkg::*;

   // one item in flight: a transfer closes the request side next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another item is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_chosen_index) && $stable(rsp_status))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NO_SERVER ||
                     rsp_status == STATUS_AT_ZERO))
      else $error("undefined status code");

   a_no_server_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NO_SERVER |-> rsp_chosen_index == '0)
      else $error("no-server response with nonzero index");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind least_connections_server_select lcs_checker u_lcs_checker (.*);
